// ----- src/apm_pkg.sv -----
// apm_pkg: shared types and constants for the alpha unpremultiply core.
// Pixel and result structs, lane status, register indexes, divider sizing.
// No dependencies.
`default_nettype none
package apm_pkg;

  localparam int ChanW    = 16;
  localparam int NumLanes = 3;
  localparam int NumW     = 2 * ChanW;
  localparam int QuoW     = ChanW + 1;
  localparam int DivSteps = QuoW;
  localparam int Latency  = DivSteps + 2;

  localparam logic [ChanW-1:0] Max8  = 16'd255;
  localparam logic [ChanW-1:0] Max16 = 16'hFFFF;

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_DEPTH  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic   enable;
    logic   depth;
    pixel_t pixel;
  } ctl_t;

  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic            ovf;
  } lane_out_t;

endpackage
`default_nettype wire

// ----- src/apm_lane.sv -----
// apm_lane: one color channel, scaled numerator then a pipelined restoring
// divider giving one quotient bit per stage. Uses apm_pkg.
`default_nettype none
module apm_lane (
  input  wire logic                      clk,
  input  wire logic [apm_pkg::ChanW-1:0] value,
  input  wire logic [apm_pkg::ChanW-1:0] alpha,
  input  wire logic                      depth,
  output apm_pkg::lane_out_t             res
);
  import apm_pkg::*;

  logic [NumW-1:0]  prod;
  logic [NumW-1:0]  num;
  logic [NumW-1:0]  v32;

  logic [ChanW-1:0] rem  [DivSteps];
  logic [QuoW-1:0]  nlo  [DivSteps];
  logic [ChanW-1:0] al   [DivSteps];
  logic [QuoW-1:0]  quo  [DivSteps+1];
  logic             ovf  [DivSteps+1];

  always_comb begin
    v32  = {{(NumW-ChanW){1'b0}}, value};
    prod = depth ? ((v32 << ChanW) - v32) : ((v32 << 8) - v32);
    num  = prod + {{(NumW-ChanW+1){1'b0}}, alpha[ChanW-1:1]};
  end

  always_ff @(posedge clk) begin
    rem[0] <= {1'b0, num[NumW-1:QuoW]};
    nlo[0] <= num[QuoW-1:0];
    al[0]  <= alpha;
    quo[0] <= '0;
    ovf[0] <= ({1'b0, num[NumW-1:QuoW]} >= alpha);
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [QuoW-1:0] r2;
    logic [QuoW-1:0] diff;
    logic            ge;

    always_comb begin
      r2   = {rem[k-1], nlo[k-1][QuoW-1]};
      diff = r2 - {1'b0, al[k-1]};
      ge   = (r2 >= {1'b0, al[k-1]});
    end

    always_ff @(posedge clk) begin
      quo[k] <= {quo[k-1][QuoW-2:0], ge};
      ovf[k] <= ovf[k-1];
    end

    if (k < DivSteps) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k] <= ge ? diff[ChanW-1:0] : r2[ChanW-1:0];
        nlo[k] <= {nlo[k-1][QuoW-2:0], 1'b0};
        al[k]  <= al[k-1];
      end
    end
  end

  assign res.quo = quo[DivSteps];
  assign res.ovf = ovf[DivSteps];

endmodule
`default_nettype wire

// ----- src/apm_merge.sv -----
// apm_merge: saturates the lane quotients, handles zero alpha and bypass,
// and registers the result with its strobe. Uses apm_pkg.
`default_nettype none
module apm_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               vld,
  input  wire apm_pkg::ctl_t      ctl,
  input  wire apm_pkg::lane_out_t lanes [apm_pkg::NumLanes],
  output logic                    done,
  output apm_pkg::result_t        result
);
  import apm_pkg::*;

  logic [ChanW-1:0] maxv;
  logic [ChanW-1:0] cooked [NumLanes];
  logic [ChanW-1:0] raw    [NumLanes];
  logic [ChanW-1:0] pick   [NumLanes];

  assign maxv   = ctl.depth ? Max16 : Max8;
  assign raw[0] = ctl.pixel.in_red;
  assign raw[1] = ctl.pixel.in_green;
  assign raw[2] = ctl.pixel.in_blue;

  for (genvar i = 0; i < NumLanes; i++) begin : g_sat
    always_comb begin
      if (ctl.pixel.in_alpha == '0) begin
        cooked[i] = '0;
      end else if (lanes[i].ovf || (lanes[i].quo > {1'b0, maxv})) begin
        cooked[i] = maxv;
      end else begin
        cooked[i] = lanes[i].quo[ChanW-1:0];
      end
      pick[i] = ctl.enable ? cooked[i] : raw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  always_ff @(posedge clk) begin
    result.out_red   <= pick[0];
    result.out_green <= pick[1];
    result.out_blue  <= pick[2];
    result.out_alpha <= ctl.pixel.in_alpha;
  end

endmodule
`default_nettype wire

// ----- src/alpha_unpremultiply_core.sv -----
// alpha_unpremultiply_core: top level, config registers, three divider lanes
// and the merge stage. Uses apm_pkg, apm_lane, apm_merge.
//
//   port group     direction  handshake
//   pixel          in         start, busy (busy is always low)
//   result         out        done strobe, one cycle, no backpressure
//   apb config     in/out     psel, penable, pwrite, pready (always high)
//
// One pixel per cycle, every cycle. Each pixel passes the numerator register,
// the 17-stage divider in each lane and the output register before its done
// strobe. Reset empties the pipeline, sets enable and selects 8-bit samples.
`default_nettype none
module alpha_unpremultiply_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire apm_pkg::pixel_t  pixel,
  output logic                  done,
  output apm_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import apm_pkg::*;

  logic      unpremultiply_enable;
  logic      sample_depth;
  reg_idx_t  reg_idx;
  logic      wr;
  logic      vld [DivSteps+1];
  ctl_t      ctl [DivSteps+1];
  logic [ChanW-1:0] chan [NumLanes];
  lane_out_t lane_res [NumLanes];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unpremultiply_enable <= 1'b1;
      sample_depth         <= 1'b0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_ENABLE: unpremultiply_enable <= pwdata[0];
        REG_DEPTH:  sample_depth         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE: prdata = {31'b0, unpremultiply_enable};
      REG_DEPTH:  prdata = {31'b0, sample_depth};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    ctl[0] <= '{enable: unpremultiply_enable, depth: sample_depth, pixel: pixel};
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      ctl[k] <= ctl[k-1];
    end
  end

  assign chan[0] = pixel.in_red;
  assign chan[1] = pixel.in_green;
  assign chan[2] = pixel.in_blue;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    apm_lane u_lane (
      .clk   (clk),
      .value (chan[i]),
      .alpha (pixel.in_alpha),
      .depth (sample_depth),
      .res   (lane_res[i])
    );
  end

  apm_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .vld    (vld[DivSteps]),
    .ctl    (ctl[DivSteps]),
    .lanes  (lane_res),
    .done   (done),
    .result (result)
  );

  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##19 done)
    else $error("request did not complete after pipeline latency");

  a_alpha : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_alpha == $past(pixel.in_alpha, 19)))
    else $error("alpha not carried with its request");

  a_bypass : assert property (@(posedge clk) disable iff (rst)
    (done && !unpremultiply_enable) |-> (result == $past(pixel, 19)))
    else $error("bypass altered the pixel");

  a_sat8 : assert property (@(posedge clk) disable iff (rst)
    (done && unpremultiply_enable && !sample_depth) |->
      (result.out_red <= Max8 && result.out_green <= Max8 && result.out_blue <= Max8))
    else $error("8-bit color above channel max");

endmodule
`default_nettype wire

// ----- dv/alpha_unpremultiply_checker.sv -----
// alpha_unpremultiply_checker: watches the pixel, result and register ports of
// alpha_unpremultiply_core, predicts each straight-alpha result and compares.
// Depends on apm_pkg for the pixel, result and register index types.
module alpha_unpremultiply_checker
  import apm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  pixel_t      pixel,
  input  logic        done,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t straight_q[$];
  logic    enable_copy;
  logic    depth_copy;

  function automatic logic [ChanW-1:0] straighten_chan(logic [ChanW-1:0] chan,
                                                       logic [ChanW-1:0] alpha,
                                                       logic [ChanW-1:0] full);
    logic [32:0] num;
    logic [32:0] quo;
    if (alpha == '0) return '0;
    num = 33'(chan) * 33'(full) + 33'(alpha >> 1);
    quo = num / 33'(alpha);
    return (quo > 33'(full)) ? full : quo[ChanW-1:0];
  endfunction

  function automatic result_t unpremultiply(pixel_t p, logic en, logic deep);
    result_t     r;
    logic [15:0] full;
    full = deep ? Max16 : Max8;
    r.out_red   = en ? straighten_chan(p.in_red, p.in_alpha, full) : p.in_red;
    r.out_green = en ? straighten_chan(p.in_green, p.in_alpha, full) : p.in_green;
    r.out_blue  = en ? straighten_chan(p.in_blue, p.in_alpha, full) : p.in_blue;
    r.out_alpha = p.in_alpha;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_ENABLE: return {31'b0, enable_copy};
      REG_DEPTH:  return {31'b0, depth_copy};
      default:    return '0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t  want;
    reg_idx_t idx;
    string    lane_name[4];
    lane_name = '{"red", "green", "blue", "alpha"};
    idx = reg_idx_t'(paddr[2]);
    if (rst) begin
      straight_q.delete();
      enable_copy = 1'b1;
      depth_copy  = 1'b0;
      mismatches  = 0;
    end else begin
      if (start && !busy) straight_q.push_back(unpremultiply(pixel, enable_copy, depth_copy));
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_ENABLE: enable_copy = pwdata[0];
            REG_DEPTH:  depth_copy  = pwdata[0];
            default: ;
          endcase
        end else if (prdata !== reg_value(idx)) begin
          report_mismatch($sformatf("register %s read %h, want %h", idx.name(), prdata,
                                    reg_value(idx)));
        end
      end
      if (done) begin
        if (straight_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request pending", result));
        end else begin
          want = straight_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (result[63-16*k -: 16] !== want[63-16*k -: 16])
              report_mismatch($sformatf("out_%s got %h, want %h", lane_name[k],
                                        result[63-16*k -: 16], want[63-16*k -: 16]));
          end
        end
      end
    end
    outstanding <= straight_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
// testbench: drives pixels and register writes into alpha_unpremultiply_core
// and gives the verdict; prediction and comparison live in the checker.
// Depends on apm_pkg, alpha_unpremultiply_core and alpha_unpremultiply_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import apm_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int RandPerPhase = 305;
  localparam bit [5:0] ModeEn   = 6'b110011;
  localparam bit [5:0] ModeDeep = 6'b010110;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pixel_t      pixel;
  logic        done;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;
  int          stall_cycles;

  alpha_unpremultiply_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  alpha_unpremultiply_checker straight_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] edge_value(logic [15:0] top);
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return top - 16'd1;
      3:       return top;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic pixel_t random_pixel(logic deep);
    pixel_t      p;
    logic [15:0] top;
    top = deep ? Max16 : Max8;
    p.in_alpha = 16'($urandom_range(1, top));
    p.in_red   = 16'($urandom_range(0, p.in_alpha));
    p.in_green = 16'($urandom_range(0, p.in_alpha));
    p.in_blue  = 16'($urandom_range(0, p.in_alpha));
    case ($urandom_range(0, 9))
      6: p.in_alpha = '0;
      7: p = pixel_t'({$urandom, $urandom});
      8: begin
        p.in_red   = edge_value(top);
        p.in_green = edge_value(top);
        p.in_blue  = edge_value(top);
        p.in_alpha = edge_value(top);
      end
      9: begin
        p.in_alpha = 16'($urandom_range(1, top >> 2));
        p.in_red   = 16'($urandom_range(0, top));
        p.in_green = 16'($urandom_range(0, top));
        p.in_blue  = 16'($urandom_range(0, top));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_pixel(pixel_t p, bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // psel stays high between back-to-back transfers; apb_release drops it
  task automatic apb_xfer(bit wr, reg_idx_t idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(logic en, logic deep);
    drain_requests();
    apb_xfer(1'b1, REG_ENABLE, {31'b0, en});
    apb_xfer(1'b1, REG_DEPTH, {31'b0, deep});
    apb_xfer(1'b0, REG_ENABLE, '0);
    apb_xfer(1'b0, REG_DEPTH, '0);
    apb_release();
  endtask

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    pixel   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: enabled, 8-bit
    apb_xfer(1'b0, REG_ENABLE, '0);
    apb_xfer(1'b0, REG_DEPTH, '0);
    apb_release();
    push_pixel(pixel_t'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
    push_pixel(pixel_t'{16'd255, 16'd128, 16'd1, 16'd0}, 1'b0);
    push_pixel(pixel_t'{16'd255, 16'd255, 16'd255, 16'd255}, 1'b0);
    push_pixel(pixel_t'{16'd1, 16'd0, 16'd2, 16'd1}, 1'b0);
    push_pixel(pixel_t'{16'd128, 16'd64, 16'd127, 16'd255}, 1'b0);
    push_pixel(pixel_t'{16'd1, 16'd1, 16'd1, 16'd2}, 1'b0);
    push_pixel(pixel_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    push_pixel(pixel_t'{16'hFFFF, 16'h8000, 16'h0000, 16'h0100}, 1'b0);
    push_pixel(pixel_t'{16'hAAAA, 16'h5555, 16'h00FF, 16'hFFFF}, 1'b0);

    set_mode(1'b1, 1'b1);
    push_pixel(pixel_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    push_pixel(pixel_t'{16'd1, 16'd32768, 16'd65534, 16'hFFFF}, 1'b0);
    push_pixel(pixel_t'{16'd1, 16'd1, 16'd1, 16'd1}, 1'b0);
    push_pixel(pixel_t'{16'd2, 16'd0, 16'hFFFF, 16'd1}, 1'b0);
    push_pixel(pixel_t'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b0);
    push_pixel(pixel_t'{16'hFFFF, 16'd1, 16'd12345, 16'd0}, 1'b0);
    push_pixel(pixel_t'{16'h5555, 16'hAAAA, 16'h0001, 16'h8000}, 1'b0);

    set_mode(1'b0, 1'b1);
    push_pixel(pixel_t'{16'hFFFF, 16'h0000, 16'h1234, 16'h0000}, 1'b0);
    push_pixel(pixel_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001}, 1'b0);

    set_mode(1'b0, 1'b0);
    push_pixel(pixel_t'{16'h0100, 16'hFFFF, 16'h0000, 16'h00FF}, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ModeEn[ph], ModeDeep[ph]);
      for (int i = 0; i < RandPerPhase; i++)
        push_pixel(random_pixel(ModeDeep[ph]), ph < 5 && ((i / 40) % 3 != 2));
    end

    drain_requests();
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
